// File: design/bspc_pkg.sv
// Package for the button short/long press classifier.
// Holds widths, register indexes, reset values and the shared struct types.
// No dependencies; every other design file imports it.
package bspc_pkg;

   // Number of tracked buttons; only the first PRESS_WIDTH can ever be pressed.
   localparam int BUTTONS     = 8;
   localparam int PRESS_WIDTH = 8;
   // One event slot per button that can fire, at most eight per poll.
   localparam int EVENT_SLOTS = 8;

   localparam int TIME_W   = 32;
   localparam int THRESH_W = 16;
   localparam int ID_W     = 8;
   localparam int INDEX_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [ID_W-1:0]     UNPAIRED_ID      = 8'hFF;
   localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd800;
   localparam logic [THRESH_W-1:0] DEBOUNCE_RESET   = 16'd50;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_DEBOUNCE   = 2'd1,
      CSR_NODE_ID    = 2'd2
   } csr_index_type;

   // Kind of press event.
   localparam logic KIND_SHORT = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

   // Configuration bundle handed to the button lanes.
   typedef struct packed {
      logic [THRESH_W-1:0] long_limit;
      logic [THRESH_W-1:0] short_limit;
      logic [ID_W-1:0]     node_id;
   } cfg_type;

   // Events produced by one poll: a hit bit and a kind bit per slot.
   typedef struct packed {
      logic [EVENT_SLOTS-1:0] hit;
      logic [EVENT_SLOTS-1:0] long_kind;
   } events_type;

endpackage

// File: design/bspc_if.sv
// Channel interfaces for the button press classifier: poll, event and register write.
// Depends on bspc_pkg for field widths.
interface bspc_req_if;
   import bspc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [TIME_W-1:0]      now_ms;
   logic [PRESS_WIDTH-1:0] buttons_pressed;
   modport source (output valid, output now_ms, output buttons_pressed, input ready);
   modport sink   (input valid, input now_ms, input buttons_pressed, output ready);
endinterface

interface bspc_rsp_if;
   import bspc_pkg::*;
   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    source_id;
   logic [INDEX_W-1:0] button_index;
   logic               press_kind;
   logic               last_event;
   modport source (output valid, output source_id, output button_index,
                   output press_kind, output last_event, input ready);
   modport sink   (input valid, input source_id, input button_index,
                   input press_kind, input last_event, output ready);
endinterface

interface bspc_csr_if;
   import bspc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/bspc_lanes.sv
// Per-button state and classification: one lane per button, all in parallel.
// Depends on bspc_pkg for widths and the cfg_type and events_type structs.
module bspc_lanes
   import bspc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance_i,
   input  logic [TIME_W-1:0]      now_ms_i,
   input  logic [PRESS_WIDTH-1:0] pressed_i,
   input  cfg_type                cfg_i,
   output events_type             events_o
);

   logic [BUTTONS-1:0] was_pressed_ff;
   logic [BUTTONS-1:0] was_pressed_in;
   logic [BUTTONS-1:0] long_done_ff;
   logic [BUTTONS-1:0] long_done_in;
   logic [TIME_W-1:0]  press_start_ff [BUTTONS];

   logic [BUTTONS-1:0] lane_pressed;
   logic [BUTTONS-1:0] lane_begin;
   logic [BUTTONS-1:0] lane_long;
   logic [BUTTONS-1:0] lane_short;
   logic [EVENT_SLOTS-1:0] slot_hit;
   logic [EVENT_SLOTS-1:0] slot_long;

   for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
      logic [TIME_W-1:0] held;

      // Buttons past the input vector never read as pressed.
      if (i < PRESS_WIDTH) begin : g_pin
         assign lane_pressed[i] = pressed_i[i];
      end else begin : g_nopin
         assign lane_pressed[i] = 1'b0;
      end

      // Held time wraps modulo 2^32.
      assign held = now_ms_i - press_start_ff[i];

      assign lane_begin[i] = lane_pressed[i] && !was_pressed_ff[i];
      assign lane_long[i]  = lane_pressed[i] && was_pressed_ff[i] && !long_done_ff[i] &&
                             (held >= TIME_W'(cfg_i.long_limit));
      assign lane_short[i] = !lane_pressed[i] && was_pressed_ff[i] && !long_done_ff[i] &&
                             (held >= TIME_W'(cfg_i.short_limit));

      assign was_pressed_in[i] = lane_pressed[i];
      assign long_done_in[i]   = lane_begin[i] ? 1'b0 :
                                 (lane_long[i] ? 1'b1 : long_done_ff[i]);

      // Press start time is recorded on the poll where a press begins.
      always_ff @(posedge clock) begin
         if (advance_i && lane_begin[i]) begin
            press_start_ff[i] <= now_ms_i;
         end
      end
   end

   // Level and long-fired flags update once per poll.
   always_ff @(posedge clock) begin
      if (reset) begin
         was_pressed_ff <= '0;
         long_done_ff   <= '0;
      end else if (advance_i) begin
         was_pressed_ff <= was_pressed_in;
         long_done_ff   <= long_done_in;
      end
   end

   // Map lanes onto event slots; slots without a lane stay quiet.
   for (genvar j = 0; j < EVENT_SLOTS; j++) begin : g_slot
      if (j < BUTTONS) begin : g_used
         assign slot_hit[j]  = lane_long[j] || lane_short[j];
         assign slot_long[j] = lane_long[j];
      end else begin : g_unused
         assign slot_hit[j]  = 1'b0;
         assign slot_long[j] = 1'b0;
      end
   end

   assign events_o.hit       = slot_hit;
   assign events_o.long_kind = slot_long;

endmodule

// File: design/button_short_long_press_classifier_top.sv
// Channel   | Direction | Handshake   | Contents
// req_if    | in        | valid/ready | now_ms, buttons_pressed (one poll)
// rsp_if    | out       | valid/ready | source_id, button_index, press_kind, last_event
// csr_if    | in        | valid/ready | index, data (register write, always ready)
//
// A poll is registered, classified from the input register and its events are parked
// in an event register; one event leaves per cycle while rsp_if is ready, so a poll
// with k events (1 to 8) takes k output handshakes. Polls without events pass at one
// per cycle. The event register is the limit: the next poll with events waits until
// the last event of the previous one is taken. Synchronous active-high reset clears the
// button level and long-fired flags and loads the register defaults.
//
// Top level of the button short/long press classifier.
// Depends on bspc_pkg, bspc_if.sv and bspc_lanes.
module button_short_long_press_classifier_top
   import bspc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bspc_req_if.sink   req_if,
   bspc_rsp_if.source rsp_if,
   bspc_csr_if.sink   csr_if
);

   cfg_type cfg_ff;

   logic                   s0_valid_ff;
   logic [TIME_W-1:0]      s0_now_ff;
   logic [PRESS_WIDTH-1:0] s0_pressed_ff;
   logic                   s0_advance;

   events_type             lane_events;
   logic [EVENT_SLOTS-1:0] poll_mask;
   logic                   poll_any;

   logic                   pend_valid_ff;
   logic [EVENT_SLOTS-1:0] pend_mask_ff;
   logic [EVENT_SLOTS-1:0] pend_kind_ff;
   logic [ID_W-1:0]        pend_id_ff;
   logic [EVENT_SLOTS-1:0] pend_rest;
   logic [INDEX_W-1:0]     pend_idx;
   logic                   pend_last;
   logic                   pend_free;
   logic                   pend_load;
   logic                   rsp_fire;

   // Register writes; unknown indexes are dropped.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_limit  <= LONG_PRESS_RESET;
         cfg_ff.short_limit <= DEBOUNCE_RESET;
         cfg_ff.node_id     <= UNPAIRED_ID;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_LONG_PRESS: cfg_ff.long_limit  <= csr_if.data;
            CSR_DEBOUNCE:   cfg_ff.short_limit <= csr_if.data;
            CSR_NODE_ID:    cfg_ff.node_id     <= csr_if.data[ID_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: holds one poll until the lanes consume it.
   assign req_if.ready = !s0_valid_ff || s0_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s0_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s0_now_ff     <= req_if.now_ms;
         s0_pressed_ff <= req_if.buttons_pressed;
      end
   end

   bspc_lanes u_lanes (
      .clock     (clock),
      .reset     (reset),
      .advance_i (s0_advance),
      .now_ms_i  (s0_now_ff),
      .pressed_i (s0_pressed_ff),
      .cfg_i     (cfg_ff),
      .events_o  (lane_events)
   );

   // While unpaired the state still moves but no event is queued.
   assign poll_mask = (cfg_ff.node_id == UNPAIRED_ID) ? '0 : lane_events.hit;
   assign poll_any  = |poll_mask;

   // Serializer: the lowest pending slot leaves first.
   always_comb begin
      pend_idx = '0;
      for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
         if (pend_mask_ff[i]) begin
            pend_idx = INDEX_W'(i);
         end
      end
   end

   assign pend_rest = pend_mask_ff & (pend_mask_ff - EVENT_SLOTS'(1));
   assign pend_last = (pend_rest == '0);
   assign rsp_fire  = rsp_if.valid && rsp_if.ready;
   assign pend_free = !pend_valid_ff || (rsp_if.ready && pend_last);

   assign s0_advance = s0_valid_ff && (!poll_any || pend_free);
   assign pend_load  = s0_advance && poll_any;

   // Event register between the lanes and the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (pend_load) begin
         pend_valid_ff <= 1'b1;
      end else if (rsp_fire && pend_last) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_load) begin
         pend_mask_ff <= poll_mask;
         pend_kind_ff <= lane_events.long_kind;
         pend_id_ff   <= cfg_ff.node_id;
      end else if (rsp_fire) begin
         pend_mask_ff <= pend_rest;
      end
   end

   assign rsp_if.valid        = pend_valid_ff;
   assign rsp_if.source_id    = pend_id_ff;
   assign rsp_if.button_index = pend_idx;
   assign rsp_if.press_kind   = pend_kind_ff[pend_idx] ? KIND_LONG : KIND_SHORT;
   assign rsp_if.last_event   = pend_last;

   // A parked transaction always has at least one event left.
   a_pend_nonempty: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_mask_ff != '0))
      else $error("event register valid with no pending event");

   // No event is ever sent from an unpaired device.
   a_no_unpaired: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.source_id != UNPAIRED_ID))
      else $error("event sent with unpaired device id");

   // Taking the last event empties the register unless a new poll moves in.
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && pend_last && !pend_load) |=> !pend_valid_ff)
      else $error("event register still valid after its last event");

   // A poll that cannot move on stays in the input register.
   a_s0_holds: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && !s0_advance) |=> (s0_valid_ff && $stable(s0_now_ff)))
      else $error("stalled poll lost from the input register");

   // A new poll with events never overwrites events still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pend_load && pend_valid_ff) |-> (rsp_fire && pend_last))
      else $error("pending events overwritten");

endmodule
